[rtl/core/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants of the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Command codes. Codes above CMD_REPORT are treated as a report.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_REPORT     = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic read;
        logic capture;
    } ctl_t;

endpackage

[rtl/core/bounded_double_ended_queue.sv]
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded double-ended queue held in a ring with head and tail pointers.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Content
// s_*       in         s_tvalid/s_tready  one command request per transfer
// m_*       out        m_tvalid/m_tready  one result per command
// cfg_*     in         cfg_valid/ready    capacity register write
//
// Each command request passes through acceptance, execution (pointer
// update and the ring write), the registered read of front and rear, and
// capture into the result register, in that order, as the single ring
// memory and its registered read ports require. The input is ready again
// in the cycle after capture, even while the result still waits on
// m_tready; a second result only waits when the first has not been taken.
// Reset clears the pointers and the count and sets the capacity register to
// 16; the ring store is not cleared, since only live entries are ever read.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    input  logic [2:0]  s_tuser,    // [2:0] cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [0] ok, [32:1] front_value,
                                    // [64:33] rear_value, [65] is_empty,
                                    // [66] is_full, [71:67] zero

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data    // capacity
);

    import bdq_pkg::*;

    ctl_t               ctl;
    logic               ok;
    logic [VALUE_W-1:0] front_value;
    logic [VALUE_W-1:0] rear_value;
    logic               is_empty;
    logic               is_full;

    // The host is to write the capacity register only while the queue is idle;
    // the block itself does not enforce this, as cfg_ready is tied high.
    assign cfg_ready = 1'b1;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    bdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .in_cmd       (s_tuser),
        .in_value     (s_tdata),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_capacity (cfg_data),
        .ok           (ok),
        .front_value  (front_value),
        .rear_value   (rear_value),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    // Result fields packed from bit zero upward, padded to whole bytes.
    assign m_tdata = {5'b0, is_full, is_empty, rear_value, front_value, ok};

endmodule

[rtl/core/bdq_ram.sv]
// ----------------------------------------------------------------------------
// bdq_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

[rtl/core/bdq_ctrl.sv]
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer of the queue: load, execute, read, deliver, one command at a time.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output bdq_pkg::ctl_t ctl
);

    import bdq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                ctl.read   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // The result register is free or empties in this cycle.
                if (!out_valid_reg || out_ready)
                begin
                    ctl.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/core/bdq_dp.sv]
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath: ring pointers, entry count, capacity register, ring store and
// the result register.
// ----------------------------------------------------------------------------
module bdq_dp #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bdq_pkg::ctl_t                 ctl,
    input  logic [bdq_pkg::CMD_W-1:0]     in_cmd,
    input  logic [bdq_pkg::VALUE_W-1:0]   in_value,
    input  logic                          cfg_we,
    input  logic [bdq_pkg::CAP_W-1:0]     cfg_capacity,
    output logic                          ok,
    output logic [bdq_pkg::VALUE_W-1:0]   front_value,
    output logic [bdq_pkg::VALUE_W-1:0]   rear_value,
    output logic                          is_empty,
    output logic                          is_full
);

    import bdq_pkg::*;

    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    cmd_t               cmd_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [PW-1:0]      head_reg;
    logic [PW-1:0]      head_next;
    logic [PW-1:0]      tail_reg;
    logic [PW-1:0]      tail_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CAP_W-1:0]   cap_reg;
    logic               ok_reg;
    logic               ok_next;

    logic [VALUE_W-1:0] front_reg;
    logic [VALUE_W-1:0] rear_reg;
    logic               out_ok_reg;
    logic               empty_reg;
    logic               full_reg;

    logic               ram_we;
    logic [PW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] rdata_front;
    logic [VALUE_W-1:0] rdata_rear;

    logic [CMPW-1:0]    cap_ext;
    logic [CMPW-1:0]    eff_cap;
    logic               full_now;
    logic               empty_now;

    function automatic logic [PW-1:0] idx_inc(input logic [PW-1:0] idx);
        return (idx == PW'(DEPTH - 1)) ? '0 : idx + PW'(1);
    endfunction

    function automatic logic [PW-1:0] idx_dec(input logic [PW-1:0] idx);
        return (idx == '0) ? PW'(DEPTH - 1) : idx - PW'(1);
    endfunction

    // A capacity above the ring depth saturates at the depth.
    assign cap_ext   = CMPW'(cap_reg);
    assign eff_cap   = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
    assign full_now  = CMPW'(count_reg) >= eff_cap;
    assign empty_now = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_capacity;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
        if (ctl.load)
        begin
            cmd_reg   <= cmd_t'(in_cmd);
            value_reg <= in_value;
        end
        if (ctl.capture)
        begin
            out_ok_reg <= ok_reg;
            front_reg  <= empty_now ? '1 : rdata_front;
            rear_reg   <= empty_now ? '1 : rdata_rear;
            empty_reg  <= empty_now;
            full_reg   <= full_now;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        ok_next    = ok_reg;
        ram_we     = 1'b0;
        ram_waddr  = tail_reg;
        if (ctl.exec)
        begin
            ok_next = 1'b1;
            unique case (cmd_reg)
                CMD_PUSH_FRONT:
                begin
                    if (full_now)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        head_next  = idx_dec(head_reg);
                        ram_we     = 1'b1;
                        ram_waddr  = idx_dec(head_reg);
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_PUSH_REAR:
                begin
                    if (full_now)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        tail_next  = idx_inc(tail_reg);
                        ram_we     = 1'b1;
                        ram_waddr  = tail_reg;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (empty_now)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        head_next  = idx_inc(head_reg);
                        count_next = count_reg - CW'(1);
                    end
                end
                CMD_POP_REAR:
                begin
                    if (empty_now)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        tail_next  = idx_dec(tail_reg);
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    ok_next = 1'b1;
                end
            endcase
        end
    end

    // Reads happen in the cycle after the pointer update, so a push is never
    // read in the same cycle as it is written.
    bdq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (value_reg),
        .re      (ctl.read),
        .raddr_a (head_reg),
        .raddr_b (idx_dec(tail_reg)),
        .rdata_a (rdata_front),
        .rdata_b (rdata_rear)
    );

    assign ok          = out_ok_reg;
    assign front_value = front_reg;
    assign rear_value  = rear_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;

endmodule

[rtl/core/bdq_checker.sv]
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks of the bounded double-ended queue.
// ----------------------------------------------------------------------------
module bdq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Only one command request is in work at a time.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in work");

    // A result never appears right after a request is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result rose one cycle after acceptance");

    // An empty queue reports all ones at both ends.
    a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[65] |-> (m_tdata[32:1] == 32'hFFFF_FFFF)
                                    && (m_tdata[64:33] == 32'hFFFF_FFFF))
        else $error("empty result with live words");

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bounded double-ended queue
// Sends command requests (pushes and pops at both ends, reports, unknown
// codes) through the stream input and rewrites the capacity register between
// phases. A behavioral copy of the queue predicts every result. A checker
// compares each result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam int RING_DEPTH = 16;
    localparam int MAX_SHOWN  = 40;

    // One result word as it leaves the block, lowest field in the lowest bits.
    typedef struct packed {
        logic [4:0]  spare;
        logic        is_full;
        logic        is_empty;
        logic [31:0] rear_value;
        logic [31:0] front_value;
        logic        ok;
    } outcome_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data  = '0;

    // Behavioral copy of the queue: ring, pointers, count and capacity.
    logic [31:0] ring_copy [RING_DEPTH];
    int          head_ptr;
    int          tail_ptr;
    int          entry_count;
    int          capacity_reg;

    outcome_t    pending_results [$];

    // Idle percentages of the current phase and the long receiver hold-off.
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          hold_off_request;
    int          hold_off_left;

    int          mismatch_count;
    int          requests_sent;
    int          results_checked;
    int          refused_count;
    int          full_results;
    int          capacity_writes;

    bounded_double_ended_queue #(
        .DEPTH (RING_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Queue behavior
    // ------------------------------------------------------------------------

    // Capacity values above the ring depth saturate to the depth. A capacity
    // of zero makes the queue empty and full at once.
    function automatic logic queue_full();
        int limit;
        limit = (capacity_reg > RING_DEPTH) ? RING_DEPTH : capacity_reg;
        return entry_count >= limit;
    endfunction

    // Applies one command to the copy of the queue and returns the result
    // that the block must produce for it. Refused commands change nothing,
    // and codes beyond the report code behave as a report.
    function automatic outcome_t apply_command(logic [2:0] code, logic [31:0] word);
        outcome_t res;
        res    = '0;
        res.ok = 1'b1;
        case (code)
            CMD_PUSH_FRONT:
                if (queue_full())
                    res.ok = 1'b0;
                else
                begin
                    head_ptr = (head_ptr == 0) ? RING_DEPTH - 1 : head_ptr - 1;
                    ring_copy[head_ptr] = word;
                    entry_count++;
                end
            CMD_PUSH_REAR:
                if (queue_full())
                    res.ok = 1'b0;
                else
                begin
                    ring_copy[tail_ptr] = word;
                    tail_ptr = (tail_ptr + 1) % RING_DEPTH;
                    entry_count++;
                end
            CMD_POP_FRONT:
                if (entry_count == 0)
                    res.ok = 1'b0;
                else
                begin
                    head_ptr = (head_ptr + 1) % RING_DEPTH;
                    entry_count--;
                end
            CMD_POP_REAR:
                if (entry_count == 0)
                    res.ok = 1'b0;
                else
                begin
                    tail_ptr = (tail_ptr == 0) ? RING_DEPTH - 1 : tail_ptr - 1;
                    entry_count--;
                end
            default:
                ;
        endcase
        // An empty queue shows all ones at both ends; note that a stored
        // all-ones word looks the same, which the directed test exercises.
        if (entry_count == 0)
        begin
            res.front_value = '1;
            res.rear_value  = '1;
        end
        else
        begin
            res.front_value = ring_copy[head_ptr];
            res.rear_value  = ring_copy[(tail_ptr == 0) ? RING_DEPTH - 1 : tail_ptr - 1];
        end
        res.is_empty = (entry_count == 0);
        res.is_full  = queue_full();
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: ready driver and checker
    // ------------------------------------------------------------------------

    // The ready line changes on the falling edge. A hold-off request from a
    // test is taken over here and counted down one cycle at a time, which
    // lets the block fill up and push back on its input.
    always @(negedge clk)
    begin
        if (hold_off_request != 0)
        begin
            hold_off_left    = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            m_tready = 1'b0;
        end
        else
            m_tready = ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < MAX_SHOWN)
            $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        else if (mismatch_count == MAX_SHOWN)
            $display("[%0t] further mismatches are counted but not shown", $realtime);
        mismatch_count++;
    endtask

    // Every result taken at a rising edge is matched against the oldest
    // prediction still waiting.
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = outcome_t'(m_tdata);
            if (pending_results.size() == 0)
                report_mismatch("result with no request waiting", m_tdata[31:0], '0);
            else
            begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch("ok", 32'(got.ok), 32'(want.ok));
                if (got.front_value !== want.front_value)
                    report_mismatch("front_value", got.front_value, want.front_value);
                if (got.rear_value !== want.rear_value)
                    report_mismatch("rear_value", got.rear_value, want.rear_value);
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
                if (got.is_full !== want.is_full)
                    report_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offers one command request. Idle cycles come first, at the phase's
    // rate, with noise on the data lines. The prediction is made at the edge
    // that accepts the request.
    task automatic send_request(logic [2:0] code, logic [31:0] word);
        outcome_t res;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid = 1'b0;
            s_tdata  = $urandom;
            s_tuser  = 3'($urandom_range(7));
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = code;
        s_tdata  = word;
        do
            @(posedge clk);
        while (!s_tready);
        res = apply_command(code, word);
        pending_results.push_back(res);
        requests_sent++;
        if (!res.ok)
            refused_count++;
        if (res.is_full)
            full_results++;
    endtask

    // Stops offering and waits until every predicted result has come back,
    // then lets the block settle.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Capacity is only rewritten while nothing is in flight.
    task automatic write_capacity(logic [4:0] cap);
        drain_results();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        capacity_reg = cap;
        capacity_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = 5'($urandom);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Picks a command; push_pct steers the queue toward full or empty.
    function automatic logic [2:0] pick_command(int push_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return CMD_REPORT;
        if (roll < 6)
            return 3'(CMD_REPORT) + 3'($urandom_range(1, 3));
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        return $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // At reset capacity: pops and reports on the empty queue, the extreme
    // words at both ends, an all-ones word that mimics the empty marker, and
    // the unknown command codes.
    task automatic test_empty_and_extremes();
        send_request(CMD_REPORT, 32'h0000_0000);
        send_request(CMD_POP_FRONT, 32'hFFFF_FFFF);
        send_request(CMD_POP_REAR, 32'h1234_5678);
        send_request(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(CMD_PUSH_REAR, 32'h8000_0000);
        send_request(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(CMD_PUSH_REAR, 32'h0000_0000);
        send_request(3'd7, 32'hDEAD_BEEF);
        send_request(3'd5, 32'h0000_0001);
        send_request(CMD_POP_FRONT, 32'h0);
        send_request(CMD_POP_REAR, 32'h0);
        send_request(CMD_POP_FRONT, 32'h0);
        send_request(CMD_POP_REAR, 32'h0);
        send_request(CMD_POP_FRONT, 32'h0);
    endtask

    // Capacity one and zero, then a capacity lowered below the entries held,
    // which must refuse pushes but keep every entry.
    task automatic test_capacity_limits();
        write_capacity(5'd1);
        send_request(CMD_PUSH_REAR, 32'hA5A5_5A5A);
        send_request(CMD_PUSH_FRONT, 32'h1111_1111);
        send_request(CMD_PUSH_REAR, 32'h2222_2222);
        send_request(CMD_POP_FRONT, 32'h0);
        send_request(CMD_REPORT, 32'h0);
        write_capacity(5'd0);
        send_request(CMD_PUSH_FRONT, 32'h3333_3333);
        send_request(CMD_POP_REAR, 32'h0);
        send_request(CMD_REPORT, 32'h0);
        write_capacity(5'd16);
        send_request(CMD_PUSH_REAR, 32'h0000_0011);
        send_request(CMD_PUSH_REAR, 32'h0000_0022);
        send_request(CMD_PUSH_FRONT, 32'h0000_0033);
        write_capacity(5'd1);
        send_request(CMD_PUSH_REAR, 32'h0000_0044);
        send_request(CMD_POP_REAR, 32'h0);
        send_request(CMD_POP_FRONT, 32'h0);
        send_request(CMD_POP_REAR, 32'h0);
    endtask

    // Random traffic in bursts that lean toward filling, toward draining, or
    // neither, so that the full and empty boundaries are crossed often.
    task automatic test_random_traffic(int count, logic [4:0] cap, int send_pct,
                                       int stall_pct);
        int push_pct;
        int burst_left;
        write_capacity(cap);
        sender_idle_pct    = send_pct;
        receiver_stall_pct = stall_pct;
        burst_left         = 0;
        push_pct           = 50;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(8, 24);
                case ($urandom_range(2))
                    0:       push_pct = 80;
                    1:       push_pct = 25;
                    default: push_pct = 50;
                endcase
            end
            burst_left--;
            send_request(pick_command(push_pct), pick_word());
        end
    endtask

    // The receiver stops for a long stretch while requests keep coming, so
    // the block has to hold its input off until results are taken again.
    task automatic test_backpressure();
        write_capacity(5'd8);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_request   = 300;
        for (int n = 0; n < 40; n++)
            send_request(pick_command(60), pick_word());
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        head_ptr           = 0;
        tail_ptr           = 0;
        entry_count        = 0;
        capacity_reg       = int'(CAP_RESET);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_request   = 0;
        hold_off_left      = 0;
        mismatch_count     = 0;
        requests_sent      = 0;
        results_checked    = 0;
        refused_count      = 0;
        full_results       = 0;
        capacity_writes    = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_and_extremes();
        test_capacity_limits();
        test_random_traffic(100, 5'd16, 0, 0);
        test_random_traffic(200, 5'd1, 83, 0);
        test_random_traffic(200, 5'd31, 0, 83);
        test_random_traffic(200, 5'd4, 6, 6);
        test_backpressure();
        test_random_traffic(60, 5'd0, 0, 0);
        test_random_traffic(200, 5'd17, 6, 6);
        test_random_traffic(200, 5'd2, 0, 0);
        test_random_traffic(200, 5'd8, 83, 0);
        test_random_traffic(200, 5'd16, 0, 83);
        drain_results();

        $display("Sent %0d command requests over %0d capacity writes; %0d results checked.",
                 requests_sent, capacity_writes, results_checked);
        $display("%0d requests were refused and %0d results reported a full queue.",
                 refused_count, full_results);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // A hung handshake ends the run here; a correct run needs well under a
    // tenth of this time.
    initial
    begin
        #(5_000_000);
        $display("Run stopped after a timeout with %0d results still waiting.",
                 pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/core/bdq_pkg.sv
rtl/core/bdq_ram.sv
rtl/core/bdq_ctrl.sv
rtl/core/bdq_dp.sv
rtl/core/bounded_double_ended_queue.sv
rtl/core/bdq_checker.sv
bench/tb_top.sv
